// File: hdl/ptdf_pkg.sv
// Package for the periodic timer with deferred fire.
// Holds the command, status and register index codes and the word types.
// No dependencies.
package ptdf_pkg;

    // Command codes of an input word.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SERVICE = 2'd1;
    localparam logic [1:0] CMD_SET     = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Timer status codes.
    localparam logic [1:0] STATUS_PLAY    = 2'd0;
    localparam logic [1:0] STATUS_PAUSED  = 2'd1;
    localparam logic [1:0] STATUS_ABORTED = 2'd2;

    // Configuration register indexes and widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_TIME_W  = 31;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOPED      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_TIME_W-1:0] RESET_FIRST_DELAY = 31'd0;
    localparam logic [CFG_TIME_W-1:0] RESET_PERIOD      = 31'd1000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] dt;
        logic        call_only_once;
        logic        end_signal;
        logic [1:0]  new_status;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pending;
        logic [15:0] fire_count;
        logic        ready_res;
    } out_word_t;

endpackage

// File: hdl/ptdf_div.sv
// Bit-serial restoring divider: one quotient bit per clock.
// Used by the timer to split elapsed time into whole goals and a remainder.
// No dependencies.
module ptdf_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0]    shifted;
    logic [W+1:0]  diff;
    logic          neg;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        neg       = diff[W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The dividend shifts out at the top while quotient bits enter below.
            rem_next = neg ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~neg};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/periodic_timer_deferred_fire_unit.sv
// Top level of the periodic timer with initial delay and deferred fire count.
// Depends on ptdf_pkg for codes and word types and on ptdf_div for the division.
//
//   Channel   Direction  Handshake            Word
//   s_        in         s_valid / s_ready    in_word_t  (cmd, dt, flags, new_status)
//   m_        out        m_valid / m_ready    out_word_t (status, pending, fires, ready)
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick word while playing goes through the divide and done states to the
// result word: the bit-serial divider produces one quotient bit per clock.
// Every other word goes straight to the done state. One word is worked on at a time.
// Reset is synchronous and active low; it restores the register defaults.
// A finished word waits in the output register while the next word is taken.
module periodic_timer_deferred_fire_unit
    import ptdf_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_payload,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Widths wide enough to compare against the saturation limits.
    localparam int PER_W = ((TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W) + 1;
    localparam int SUM_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
    localparam int SAT_W = ((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS) + 1;
    localparam int FW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [TIME_BITS-1:0]  TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [SAT_W-1:0]      COUNT_MAXW = SAT_W'(COUNT_MAX);
    localparam logic [TIME_BITS-1:0]  RESET_GOAL =
        (TIME_BITS >= 10) ? TIME_BITS'(1000) : TIME_MAX;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CFG_TIME_W-1:0] first_delay_reg, first_delay_next;
    logic [CFG_TIME_W-1:0] period_reg, period_next;
    logic                  looped_reg, looped_next;
    logic [1:0]            status_reg, status_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]  goal_reg, goal_next;
    logic [COUNT_BITS-1:0] pending_reg, pending_next;
    logic                  armed_reg, armed_next;
    logic [15:0]           fires_reg, fires_next;
    logic                  m_valid_reg, m_valid_next;
    out_word_t             m_payload_reg, m_payload_next;

    logic [PER_W-1:0]      per_w;
    logic [PER_W-1:0]      goal_sum;
    logic [TIME_BITS-1:0]  eff_period;
    logic [TIME_BITS-1:0]  first_goal;
    logic [SUM_W-1:0]      tick_sum;
    logic [TIME_BITS-1:0]  tick_elapsed;
    logic [SAT_W-1:0]      pend_sum;
    logic [COUNT_BITS-1:0] pend_sat;
    logic [FW-1:0]         pend_fw;
    logic [15:0]           drain_fires;
    logic                  accept;
    logic                  playing;
    logic                  div_start;
    logic                  div_done;
    logic [TIME_BITS-1:0]  div_quot;
    logic [TIME_BITS-1:0]  div_rem;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign playing   = (status_reg == STATUS_PLAY);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Goal values. A zero period counts as one, and both goals saturate at
    // the largest time value.
    always_comb begin
        per_w      = (period_reg == '0) ? PER_W'(1) : PER_W'(period_reg);
        eff_period = (per_w > PER_W'(TIME_MAX)) ? TIME_MAX : per_w[TIME_BITS-1:0];
        goal_sum   = PER_W'(first_delay_reg) + PER_W'(eff_period);
        first_goal = (goal_sum > PER_W'(TIME_MAX)) ? TIME_MAX : goal_sum[TIME_BITS-1:0];
    end

    // Elapsed time after a tick, saturating.
    always_comb begin
        tick_sum     = SUM_W'(elapsed_reg) + SUM_W'(s_payload.dt);
        tick_elapsed = (tick_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : tick_sum[TIME_BITS-1:0];
    end

    // Whole goals elapsed are added to the pending count, saturating.
    always_comb begin
        pend_sum = SAT_W'(div_quot) + SAT_W'(pending_reg);
        pend_sat = (pend_sum > COUNT_MAXW) ? COUNT_MAX : pend_sum[COUNT_BITS-1:0];
    end

    // A drain fires every pending callback; the reported count is clipped.
    always_comb begin
        pend_fw     = FW'(pending_reg);
        drain_fires = (pend_fw > FW'(16'hFFFF)) ? 16'hFFFF : pend_fw[15:0];
    end

    // The divider starts in the acceptance cycle of a tick while playing.
    // The goal is never zero, so the divisor is always valid.
    assign div_start = accept && (s_payload.cmd == CMD_TICK) && playing;

    ptdf_div #(
        .W(TIME_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (tick_elapsed),
        .divisor   (goal_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Configuration writes: user sends them while the timer is idle; not enforced.
    always_comb begin
        first_delay_next = first_delay_reg;
        period_next      = period_reg;
        looped_next      = looped_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FIRST_DELAY: first_delay_next = cfg_data[CFG_TIME_W-1:0];
                CFG_PERIOD:      period_next      = cfg_data[CFG_TIME_W-1:0];
                CFG_LOOPED:      looped_next      = cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Command sequencer. Non-tick commands update the state in the
    // acceptance cycle; a tick while playing finishes when the divider reports done.
    // The result word is formed from the updated state in the done state.
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        elapsed_next   = elapsed_reg;
        goal_next      = goal_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        fires_next     = fires_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fires_next = 16'd0;
                    state_next = ST_DONE;
                    case (s_payload.cmd)
                        CMD_TICK: begin
                            if (playing) begin
                                state_next = ST_DIV;
                            end
                        end
                        CMD_SERVICE: begin
                            if (playing && armed_reg) begin
                                if (!looped_reg) begin
                                    // A one-shot timer fires once and aborts.
                                    fires_next   = 16'd1;
                                    armed_next   = 1'b0;
                                    pending_next = '0;
                                    status_next  = STATUS_ABORTED;
                                end else if (s_payload.call_only_once) begin
                                    fires_next   = 16'd1;
                                    pending_next = '0;
                                end else if (pending_reg != '0) begin
                                    if (s_payload.end_signal) begin
                                        fires_next   = 16'd1;
                                        pending_next = pending_reg - COUNT_BITS'(1);
                                    end else begin
                                        fires_next   = drain_fires;
                                        pending_next = '0;
                                    end
                                end
                            end
                        end
                        CMD_SET: begin
                            if (s_payload.new_status inside
                                    {STATUS_PLAY, STATUS_PAUSED, STATUS_ABORTED}) begin
                                status_next = s_payload.new_status;
                            end
                        end
                        CMD_RESTART: begin
                            status_next  = STATUS_PLAY;
                            elapsed_next = '0;
                            goal_next    = first_goal;
                            armed_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // A nonzero quotient means the goal was reached, after
                    // which the goal becomes the plain period.
                    elapsed_next = div_rem;
                    pending_next = pend_sat;
                    if (div_quot != '0) begin
                        goal_next = eff_period;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.status     = status_reg;
                    m_payload_next.pending    = pend_fw[15:0];
                    m_payload_next.fire_count = fires_reg;
                    m_payload_next.ready_res  = playing && armed_reg && (pending_reg != '0);
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            first_delay_reg <= RESET_FIRST_DELAY;
            period_reg      <= RESET_PERIOD;
            looped_reg      <= 1'b1;
            status_reg      <= STATUS_PLAY;
            elapsed_reg     <= '0;
            goal_reg        <= RESET_GOAL;
            pending_reg     <= '0;
            armed_reg       <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            first_delay_reg <= first_delay_next;
            period_reg      <= period_next;
            looped_reg      <= looped_next;
            status_reg      <= status_next;
            elapsed_reg     <= elapsed_next;
            goal_reg        <= goal_next;
            pending_reg     <= pending_next;
            armed_reg       <= armed_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fires_reg     <= fires_next;
        m_payload_reg <= m_payload_next;
    end

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // After a word is accepted, no second word is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while a word is in progress");

    // A finished word reaches the output register once it is free.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished word not loaded into the output register");

    // A tick that starts the divider moves the sequencer into the divide state.
    a_tick_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started without entering the divide state");

endmodule
